// ===== rtl/circle_pair_collision_detect_macros.svh =====
// Assertion macros shared by the circle pair collision detector.
`ifndef CIRCLE_PAIR_COLLISION_DETECT_MACROS_SVH
`define CIRCLE_PAIR_COLLISION_DETECT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define CPCD_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed: %s", "lbl");

// Consequent must hold in the same cycle as the antecedent.
`define CPCD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %s", "lbl");

`endif

// ===== rtl/cpcd_pkg.sv =====
// Package with constants and types of the circle pair collision detector.
package cpcd_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int HIT_W       = $clog2(STORE_DEPTH);
    localparam int Q_DEPTH     = 2;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int Q_CW        = $clog2(Q_DEPTH + 1);

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic        start_frame;
        logic        killed;
        logic [15:0] entity_id;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [63:0] half_x;
        logic [63:0] half_z;
    } t_cmd;

    // One stored circle.
    typedef struct packed {
        logic [15:0] entity_id;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [63:0] half_x;
        logic [63:0] half_z;
    } t_entry;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic             idle;
        logic [CNT_W-1:0] count;
    } t_back_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SWEEP,
        BK_DRAIN,
        BK_FLUSH
    } t_back_state;

endpackage

// ===== rtl/cpcd_ifs.sv =====
// Valid/ready channel interfaces for input circles and result pairs.
interface cpcd_in_if;
    logic               valid;
    logic               ready;
    logic               start_frame;
    logic               killed;
    logic [15:0]        entity_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        radius;
    logic [31:0]        scale_x;
    logic [31:0]        scale_z;

    modport source (output valid, start_frame, killed, entity_id, pos_x, pos_y, pos_z,
                    radius, scale_x, scale_z, input ready);
    modport sink (input valid, start_frame, killed, entity_id, pos_x, pos_y, pos_z,
                  radius, scale_x, scale_z, output ready);
endinterface

interface cpcd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] earlier_entity;
    logic [15:0] new_entity;
    logic        last_of_run;

    modport source (output valid, earlier_entity, new_entity, last_of_run, input ready);
    modport sink (input valid, earlier_entity, new_entity, last_of_run, output ready);
endinterface

// ===== rtl/cpcd_front.sv =====
// Front part: accepts input words and computes the scaled half extents.
module cpcd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cpcd_in_if.sink            i_in,
    input  cpcd_pkg::t_q_status i_q_status,
    output cpcd_pkg::t_push    o_push
);

    logic        r_valid;
    logic        r_start;
    logic        r_killed;
    logic [15:0] r_id;
    logic [31:0] r_px, r_py, r_pz;
    logic [31:0] r_rad, r_sx, r_sz;
    logic        w_push;

    assign w_push     = r_valid && !i_q_status.full;
    assign i_in.ready = !r_valid || w_push;

    // Input register; holds the word until the queue takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_start  <= i_in.start_frame;
            r_killed <= i_in.killed;
            r_id     <= i_in.entity_id;
            r_px     <= i_in.pos_x;
            r_py     <= i_in.pos_y;
            r_pz     <= i_in.pos_z;
            r_rad    <= i_in.radius;
            r_sx     <= i_in.scale_x;
            r_sz     <= i_in.scale_z;
        end
    end

    // Half extents radius*scale go straight into the queue registers.
    always_comb begin
        o_push.valid           = w_push;
        o_push.cmd.start_frame = r_start;
        o_push.cmd.killed      = r_killed;
        o_push.cmd.entity_id   = r_id;
        o_push.cmd.pos_x       = r_px;
        o_push.cmd.pos_y       = r_py;
        o_push.cmd.pos_z       = r_pz;
        o_push.cmd.half_x      = 64'(r_rad) * 64'(r_sx);
        o_push.cmd.half_z      = 64'(r_rad) * 64'(r_sz);
    end

endmodule

// ===== rtl/cpcd_queue.sv =====
// Short command queue between the front and the back.
module cpcd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpcd_pkg::t_push     i_push,
    input  logic                i_pop,
    output cpcd_pkg::t_cmd      o_cmd,
    output cpcd_pkg::t_q_status o_status
);

    cpcd_pkg::t_cmd               r_mem [cpcd_pkg::Q_DEPTH];
    logic [cpcd_pkg::Q_AW-1:0]    r_wp, r_rp;
    logic [cpcd_pkg::Q_CW-1:0]    r_cnt;

    assign o_cmd          = r_mem[r_rp];
    assign o_status.full  = (r_cnt == cpcd_pkg::Q_CW'(cpcd_pkg::Q_DEPTH));
    assign o_status.empty = (r_cnt == '0);

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) begin
                r_wp <= (r_wp == cpcd_pkg::Q_AW'(cpcd_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == cpcd_pkg::Q_AW'(cpcd_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + cpcd_pkg::Q_CW'(i_push.valid) - cpcd_pkg::Q_CW'(i_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.cmd;
        end
    end

endmodule

// ===== rtl/cpcd_back.sv =====
// Back part: circle store, sweep over stored circles and pair output.
module cpcd_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cpcd_pkg::t_cmd         i_cmd,
    input  cpcd_pkg::t_q_status    i_q_status,
    output logic                   o_pop,
    output cpcd_pkg::t_back_status o_status,
    cpcd_out_if.source             o_out
);

    cpcd_pkg::t_back_state r_state, n_state;
    cpcd_pkg::t_entry      r_store [cpcd_pkg::STORE_DEPTH];

    logic [cpcd_pkg::CNT_W-1:0] r_count, r_lim, r_idx, w_lim;
    logic [cpcd_pkg::HIT_W-1:0] r_hits;
    cpcd_pkg::t_entry           r_new, r_rd;
    logic                       w_en, w_issue, w_write, w_last_issue, w_empty;

    // Pipeline registers.
    logic         r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    logic [15:0]  r_s2_id, r_s3_id, r_s4_id;
    logic [31:0]  r_dx, r_dy, r_dz;
    logic [64:0]  r_hx, r_hz;
    logic         r_s3_in, r_s4_in;
    logic [63:0]  r_sqx, r_sqy, r_sqz, r_pll;
    logic [64:0]  r_phl;
    logic [65:0]  r_phh;
    logic [65:0]  r_d2;
    logic [129:0] r_hx2;
    logic         w_hit;

    logic         r_pend_v;
    logic [15:0]  r_pend_id;
    logic         r_o_v, r_o_last;
    logic [15:0]  r_o_early, r_o_new;

    assign w_en         = !r_o_v || o_out.ready;
    assign w_lim        = i_cmd.start_frame ? '0 : r_count;
    assign w_last_issue = (r_idx + 1'b1 == r_lim);
    assign w_empty      = !r_s1_v && !r_s2_v && !r_s3_v && !r_s4_v;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cpcd_pkg::BK_IDLE: begin
                if (!i_q_status.empty && !i_cmd.killed && w_lim != '0) begin
                    n_state = cpcd_pkg::BK_SWEEP;
                end
            end
            cpcd_pkg::BK_SWEEP: begin
                if (w_en && w_last_issue) begin
                    n_state = cpcd_pkg::BK_DRAIN;
                end
            end
            cpcd_pkg::BK_DRAIN: begin
                if (w_empty) begin
                    n_state = cpcd_pkg::BK_FLUSH;
                end
            end
            cpcd_pkg::BK_FLUSH: begin
                if (w_en) begin
                    n_state = cpcd_pkg::BK_IDLE;
                end
            end
            default: n_state = cpcd_pkg::BK_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_pop   = 1'b0;
        w_issue = 1'b0;
        unique case (r_state)
            cpcd_pkg::BK_IDLE:  o_pop   = !i_q_status.empty;
            cpcd_pkg::BK_SWEEP: w_issue = w_en;
            cpcd_pkg::BK_DRAIN: w_issue = 1'b0;
            cpcd_pkg::BK_FLUSH: w_issue = 1'b0;
            default:            o_pop   = 1'b0;
        endcase
    end

    assign w_write = o_pop && !i_cmd.killed && (w_lim < cpcd_pkg::CNT_W'(cpcd_pkg::STORE_DEPTH));

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpcd_pkg::BK_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_count <= w_write ? w_lim + 1'b1 : w_lim;
            end
        end
    end

    // Store write of the new circle and registered sweep read.
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_store[w_lim[cpcd_pkg::IDX_W-1:0]] <= '{i_cmd.entity_id, i_cmd.pos_x,
                i_cmd.pos_y, i_cmd.pos_z, i_cmd.half_x, i_cmd.half_z};
        end
        if (w_issue) begin
            r_rd <= r_store[r_idx[cpcd_pkg::IDX_W-1:0]];
        end
    end

    // Item context and sweep index.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_new <= '{i_cmd.entity_id, i_cmd.pos_x, i_cmd.pos_y, i_cmd.pos_z,
                       i_cmd.half_x, i_cmd.half_z};
            r_lim <= w_lim;
            r_idx <= '0;
        end else if (w_issue) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= w_issue;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    // Pipeline datapath: distances, extent sums, products, sums.
    always_ff @(posedge i_clk) begin
        logic [32:0] ax, bx, ay, by, az, bz, sx, sy, sz;
        if (w_en) begin
            ax = {1'b0, ~r_rd.pos_x[31], r_rd.pos_x[30:0]};
            bx = {1'b0, ~r_new.pos_x[31], r_new.pos_x[30:0]};
            ay = {1'b0, ~r_rd.pos_y[31], r_rd.pos_y[30:0]};
            by = {1'b0, ~r_new.pos_y[31], r_new.pos_y[30:0]};
            az = {1'b0, ~r_rd.pos_z[31], r_rd.pos_z[30:0]};
            bz = {1'b0, ~r_new.pos_z[31], r_new.pos_z[30:0]};
            sx = ax - bx;
            sy = ay - by;
            sz = az - bz;
            // Stage 2: absolute differences and summed half extents.
            r_s2_id <= r_rd.entity_id;
            r_dx    <= sx[32] ? 32'(bx - ax) : sx[31:0];
            r_dy    <= sy[32] ? 32'(by - ay) : sy[31:0];
            r_dz    <= sz[32] ? 32'(bz - az) : sz[31:0];
            r_hx    <= {1'b0, r_rd.half_x} + {1'b0, r_new.half_x};
            r_hz    <= {1'b0, r_rd.half_z} + {1'b0, r_new.half_z};
            // Stage 3: interval tests, squares and partial products of hx^2.
            r_s3_id <= r_s2_id;
            r_s3_in <= (65'({r_dx, 16'b0}) < r_hx) && (65'({r_dz, 16'b0}) < r_hz);
            r_sqx   <= 64'(r_dx) * 64'(r_dx);
            r_sqy   <= 64'(r_dy) * 64'(r_dy);
            r_sqz   <= 64'(r_dz) * 64'(r_dz);
            r_pll   <= 64'(r_hx[31:0]) * 64'(r_hx[31:0]);
            r_phl   <= 65'(r_hx[64:32]) * 65'(r_hx[31:0]);
            r_phh   <= 66'(r_hx[64:32]) * 66'(r_hx[64:32]);
            // Stage 4: squared distance and squared extent sum.
            r_s4_id <= r_s3_id;
            r_s4_in <= r_s3_in;
            r_d2    <= 66'(r_sqx) + 66'(r_sqy) + 66'(r_sqz);
            r_hx2   <= {r_phh, 64'b0} + 130'({r_phl, 33'b0}) + 130'(r_pll);
        end
    end

    assign w_hit = r_s4_v && r_s4_in && (130'({r_d2, 32'b0}) < r_hx2);

    // A hit is held back one step so the last pair of the item can be marked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v    <= 1'b0;
            r_pend_v <= 1'b0;
        end else if (o_pop) begin
            r_pend_v <= 1'b0;
            r_hits   <= '0;
            if (w_en) begin
                r_o_v <= 1'b0;
            end
        end else if (w_en) begin
            r_o_v <= 1'b0;
            if (w_hit && r_hits != cpcd_pkg::HIT_W'(cpcd_pkg::STORE_DEPTH - 1)) begin
                r_hits    <= r_hits + 1'b1;
                r_pend_v  <= 1'b1;
                r_pend_id <= r_s4_id;
                if (r_pend_v) begin
                    r_o_v     <= 1'b1;
                    r_o_early <= r_pend_id;
                    r_o_new   <= r_new.entity_id;
                    r_o_last  <= 1'b0;
                end
            end else if (r_state == cpcd_pkg::BK_FLUSH && r_pend_v) begin
                r_pend_v  <= 1'b0;
                r_o_v     <= 1'b1;
                r_o_early <= r_pend_id;
                r_o_new   <= r_new.entity_id;
                r_o_last  <= 1'b1;
            end
        end
    end

    assign o_out.valid          = r_o_v;
    assign o_out.earlier_entity = r_o_early;
    assign o_out.new_entity     = r_o_new;
    assign o_out.last_of_run    = r_o_last;
    assign o_status.idle        = (r_state == cpcd_pkg::BK_IDLE);
    assign o_status.count       = r_count;

endmodule

// ===== rtl/circle_pair_collision_detect.sv =====
// Path: an item passes the front's input register and the queue to reach the back; each
// pair passes the store read, the pipeline and a pending register, held there until the
// next hit or sweep end. Throughput: one stored circle read per cycle from the store's
// read port unless the output stalls; a killed item or an empty store gets no sweep.
// Reset: synchronous, active low; clears the count, queue and pipeline valid bits.
// Store contents are not cleared; only entries below the count are ever read.
`include "circle_pair_collision_detect_macros.svh"
module circle_pair_collision_detect (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpcd_in_if.sink    i_in,
    cpcd_out_if.source o_out
);

    cpcd_pkg::t_push        w_push;
    cpcd_pkg::t_cmd         w_cmd;
    cpcd_pkg::t_q_status    w_q_status;
    cpcd_pkg::t_back_status w_back_status;
    logic                   w_pop;

    cpcd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (w_q_status),
        .o_push     (w_push)
    );

    cpcd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_pop    (w_pop),
        .o_cmd    (w_cmd),
        .o_status (w_q_status)
    );

    cpcd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_status   (w_back_status),
        .o_out      (o_out)
    );

    // The queue never overflows or underflows, and the store count stays in range.
    `CPCD_ASSERT_IMPL(a_no_push_full, w_push.valid, !w_q_status.full)
    `CPCD_ASSERT_IMPL(a_pop_idle, w_pop, !w_q_status.empty && w_back_status.idle)
    `CPCD_ASSERT_ALWAYS(a_count_range, w_back_status.count <= cpcd_pkg::CNT_W'(cpcd_pkg::STORE_DEPTH))

endmodule

// ===== dv/tb_circle_pair_collision_detect.sv =====
// Self-checking testbench for the circle pair collision detector.
`timescale 1ns / 1ps

// One circle collider as offered to the block.
typedef struct {
    bit          start_frame;
    bit          killed;
    bit [15:0]   entity_id;
    bit [31:0]   pos_x;
    bit [31:0]   pos_y;
    bit [31:0]   pos_z;
    bit [31:0]   radius;
    bit [31:0]   scale_x;
    bit [31:0]   scale_z;
} t_circle_word;

// One expected collision pair.
typedef struct packed {
    bit [15:0] earlier_entity;
    bit [15:0] new_entity;
    bit        last_of_run;
} t_pair_word;

// Scoreboard: keeps its own frame of circles and the queue of expected pairs.
class collision_scoreboard;
    t_circle_word frame_circles[$];
    t_pair_word   pending_pairs[$];
    int           mismatches;
    int           pairs_seen;
    int           hits_total;

    // Distance between two signed Q16.16 coordinates.
    static function bit [32:0] span(bit [31:0] a, bit [31:0] b);
        bit signed [32:0] d;
        d = $signed({a[31], a}) - $signed({b[31], b});
        return d < 0 ? -d : d;
    endfunction

    // Exact fixed-point overlap test of two circles.
    static function bit overlaps(t_circle_word a, t_circle_word b);
        bit [32:0]  dx, dy, dz;
        bit [64:0]  hx, hz;
        bit [191:0] d2, h2;
        dx = span(a.pos_x, b.pos_x);
        dy = span(a.pos_y, b.pos_y);
        dz = span(a.pos_z, b.pos_z);
        hx = 65'(64'(a.radius) * a.scale_x) + 65'(64'(b.radius) * b.scale_x);
        hz = 65'(64'(a.radius) * a.scale_z) + 65'(64'(b.radius) * b.scale_z);
        if (!({dx, 16'd0} < 192'(hx))) return 0;
        if (!({dz, 16'd0} < 192'(hz))) return 0;
        d2 = 192'(dx) * dx + 192'(dy) * dy + 192'(dz) * dz;
        h2 = 192'(hx) * 192'(hx);
        return (d2 << 32) < h2;
    endfunction

    // Notes an accepted circle and queues the pairs it causes.
    function void note_circle(t_circle_word c);
        t_pair_word p;
        int first;
        int n;
        if (c.start_frame) frame_circles.delete();
        if (c.killed) return;
        first = pending_pairs.size();
        n = 0;
        foreach (frame_circles[i]) begin
            if (n >= cpcd_pkg::STORE_DEPTH - 1) break;
            if (overlaps(frame_circles[i], c)) begin
                p.earlier_entity = frame_circles[i].entity_id;
                p.new_entity = c.entity_id;
                p.last_of_run = 0;
                pending_pairs = {pending_pairs, p};
                n++;
            end
        end
        if (n > 0) pending_pairs[first + n - 1].last_of_run = 1;
        hits_total += n;
        if (frame_circles.size() < cpcd_pkg::STORE_DEPTH) frame_circles = {frame_circles, c};
    endfunction

    // Checks one accepted pair against the oldest expectation.
    function void check_pair(t_pair_word got);
        t_pair_word want;
        pairs_seen++;
        if (pending_pairs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected pair %0d/%0d last %0d", got.earlier_entity,
                         got.new_entity, got.last_of_run);
            return;
        end
        want = pending_pairs.pop_front();
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Pair mismatch: expected %0d/%0d last %0d, got %0d/%0d last %0d",
                         want.earlier_entity, want.new_entity, want.last_of_run,
                         got.earlier_entity, got.new_entity, got.last_of_run);
        end
    endfunction
endclass

module tb_circle_pair_collision_detect;
    logic i_clk = 0;
    logic i_rst_n = 0;

    cpcd_in_if  in_ch();
    cpcd_out_if out_ch();

    circle_pair_collision_detect DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    collision_scoreboard board = new();
    int  circles_sent;
    bit  calm_phase;
    bit  long_holdoff;
    int  cycles;

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) cycles <= cycles + 1;

    // Sample accepted words at the rising edge.
    always @(posedge i_clk) begin
        t_pair_word got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.earlier_entity = out_ch.earlier_entity;
            got.new_entity = out_ch.new_entity;
            got.last_of_run = out_ch.last_of_run;
            board.check_pair(got);
        end
    end

    // Receiver: random stall bursts, one long hold-off, none near the end.
    initial begin
        int burst;
        out_ch.ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_holdoff) begin
                out_ch.ready <= 0;
                repeat (400) @(negedge i_clk);
                long_holdoff = 0;
            end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 11);
                out_ch.ready <= 0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1;
            end
        end
    end

    // Offers one circle and waits for it to be taken.
    task automatic send_circle(t_circle_word c);
        in_ch.valid <= 1;
        in_ch.start_frame <= c.start_frame;
        in_ch.killed <= c.killed;
        in_ch.entity_id <= c.entity_id;
        in_ch.pos_x <= c.pos_x;
        in_ch.pos_y <= c.pos_y;
        in_ch.pos_z <= c.pos_z;
        in_ch.radius <= c.radius;
        in_ch.scale_x <= c.scale_x;
        in_ch.scale_z <= c.scale_z;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_circle(c);
        circles_sent++;
        @(negedge i_clk);
        if (!calm_phase && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
    endtask

    function automatic t_circle_word make_circle(bit sf, bit k, bit [15:0] id,
            bit [31:0] x, bit [31:0] y, bit [31:0] z, bit [31:0] r,
            bit [31:0] sx, bit [31:0] sz);
        t_circle_word c;
        c.start_frame = sf; c.killed = k; c.entity_id = id;
        c.pos_x = x; c.pos_y = y; c.pos_z = z;
        c.radius = r; c.scale_x = sx; c.scale_z = sz;
        return c;
    endfunction

    // Random circle, mostly clustered in a small area so that overlaps are common.
    function automatic t_circle_word rand_circle(bit sf);
        t_circle_word c;
        int mode;
        mode = $urandom_range(0, 9);
        c.start_frame = sf;
        c.killed = ($urandom_range(0, 11) == 0);
        c.entity_id = 16'($urandom);
        if (mode == 0) begin
            c.pos_x = $urandom; c.pos_y = $urandom; c.pos_z = $urandom;
            c.radius = $urandom; c.scale_x = $urandom; c.scale_z = $urandom;
        end else begin
            c.pos_x = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            c.pos_y = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            c.pos_z = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            c.radius = $urandom_range(0, 32'h0002_0000);
            c.scale_x = $urandom_range(0, 32'h0002_0000);
            c.scale_z = $urandom_range(0, 32'h0002_0000);
        end
        return c;
    endfunction

    // Stops offering and waits until every expected pair has come.
    task automatic wait_drained();
        in_ch.valid <= 0;
        while (board.pending_pairs.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    // Stimulus.
    initial begin
        t_circle_word c;
        int frame_left;
        in_ch.valid = 0;
        in_ch.start_frame = 0;
        in_ch.killed = 0;
        in_ch.entity_id = 0;
        in_ch.pos_x = 0;
        in_ch.pos_y = 0;
        in_ch.pos_z = 0;
        in_ch.radius = 0;
        in_ch.scale_x = 0;
        in_ch.scale_z = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: coincident, zero sizes, extremes, killed start, far apart.
        send_circle(make_circle(1, 0, 16'h0000, 0, 0, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000));
        send_circle(make_circle(0, 0, 16'hFFFF, 0, 0, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000));
        send_circle(make_circle(0, 0, 16'h0002, 0, 0, 0, 0, 32'h1_0000, 32'h1_0000));
        send_circle(make_circle(0, 0, 16'h0003, 0, 0, 0, 32'h1_0000, 0, 32'h1_0000));
        send_circle(make_circle(0, 0, 16'h0004, 0, 0, 0, 32'h1_0000, 32'h1_0000, 0));
        send_circle(make_circle(0, 0, 16'h0005, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_circle(make_circle(0, 0, 16'h0006, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_circle(make_circle(0, 1, 16'h0007, 0, 0, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000));
        send_circle(make_circle(0, 0, 16'h0008, 32'h2_0000, 0, 0,
                                32'h1_0000, 32'h1_0000, 32'h1_0000));
        send_circle(make_circle(0, 0, 16'h0009, 32'h7000_0000, 0, 0,
                                32'h1_0000, 32'h1_0000, 32'h1_0000));
        send_circle(make_circle(1, 1, 16'h000A, 0, 0, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000));
        send_circle(make_circle(0, 0, 16'h000B, 0, 0, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000));

        // Full store: 70 coincident circles so the hit cap and full store are reached.
        for (int i = 0; i < 70; i++)
            send_circle(make_circle(i == 0, 0, 16'(100 + i), 0, 0, 0,
                                    32'h1_0000, 32'h1_0000, 32'h1_0000));
        // The sender pauses until every pair has come.
        wait_drained();

        // Random frames; partway through the receiver holds off for a long stretch.
        frame_left = 0;
        for (int i = 0; i < 190; i++) begin
            if (i == 40) long_holdoff = 1;
            if (i == 150) calm_phase = 1;
            c = rand_circle(frame_left == 0);
            if (frame_left == 0) frame_left = $urandom_range(1, 14);
            frame_left--;
            send_circle(c);
        end
        wait_drained();
    end

    // Finish once all circles are in and no pair is outstanding.
    initial begin
        wait (circles_sent == 272);
        while (board.pending_pairs.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        $display("Sent %0d circles in random frames, checked %0d pairs (%0d predicted).",
                 circles_sent, board.pairs_seen, board.hits_total);
        if (board.mismatches == 0 && board.pending_pairs.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", board.mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #20ms;
        $display("Timeout after %0d cycles", cycles);
        $display("TEST FAILED");
        $finish;
    end
endmodule
